### rtl/tfl_pkg.sv
`timescale 1ns / 1ps

package tfl_pkg;

  // Field widths of one request and one response beat.
  localparam int PAGE_W = 8;
  localparam int FRAME_W = 8;
  localparam int OCC_W = 5;

  // Default buffer depth.
  localparam int TLB_ENTRIES_DEF = 16;

  // Request codes.
  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_FILL = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // Register the request beat.
    logic execute;  // Search, update the entries and load the response.
  } ctl_cmd_t;

endpackage

### rtl/tfl_ctrl.sv
`timescale 1ns / 1ps

module tfl_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output tfl_pkg::ctl_cmd_t cmd
);
  import tfl_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;
  logic   out_free;

  // The response register can take a new beat when empty or being drained.
  assign out_free = !out_valid || !out_stall;

  // One request is held at a time; a new one is taken only while idle.
  assign in_stall = (state == S_EXEC);
  assign cmd.capture = (state == S_IDLE) && in_valid;
  assign cmd.execute = (state == S_EXEC) && out_free;

  // State and response valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_EXEC;
          end
          if (!out_stall) begin
            out_valid <= 1'b0;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            state <= S_IDLE;
            out_valid <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
          out_valid <= 1'b0;
        end
      endcase
    end
  end

endmodule

### rtl/tfl_dp.sv
`timescale 1ns / 1ps

module tfl_dp #(
  parameter int TLB_ENTRIES = tfl_pkg::TLB_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  tfl_pkg::ctl_cmd_t           cmd,
  input  logic                        req_type,
  input  logic [tfl_pkg::PAGE_W-1:0]  page,
  input  logic [tfl_pkg::FRAME_W-1:0] frame,
  output logic                        hit,
  output logic [tfl_pkg::FRAME_W-1:0] frame_out,
  output logic [tfl_pkg::OCC_W-1:0]   occupancy
);
  import tfl_pkg::*;

  localparam int CNT_W = $clog2(TLB_ENTRIES + 1);

  // Registered request.
  logic               req_q;
  logic [PAGE_W-1:0]  page_q;
  logic [FRAME_W-1:0] frame_q;

  // Entries in age order: slot 0 is the oldest.
  logic [PAGE_W-1:0]  entry_page  [TLB_ENTRIES];
  logic [FRAME_W-1:0] entry_frame [TLB_ENTRIES];
  logic [CNT_W-1:0]   count;

  logic [TLB_ENTRIES-1:0] match_vec;
  logic [TLB_ENTRIES-1:0] first_vec;
  logic [TLB_ENTRIES-1:0] rm_mask;
  logic                   found;
  logic                   full;
  logic                   is_fill;
  logic                   removed;
  logic [FRAME_W-1:0]     fout;
  logic [CNT_W-1:0]       wr_slot;
  logic [CNT_W-1:0]       count_next;
  logic [PAGE_W-1:0]      shift_page  [TLB_ENTRIES];
  logic [FRAME_W-1:0]     shift_frame [TLB_ENTRIES];

  // Capture the request beat.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req_type;
      page_q <= page;
      frame_q <= frame;
    end
  end

  // Parallel compare against the valid slots.
  always_comb begin
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      match_vec[i] = (CNT_W'(i) < count) && (entry_page[i] == page_q);
    end
  end

  // Isolate the oldest match and read its frame.
  assign first_vec = match_vec & (~match_vec + TLB_ENTRIES'(1));
  assign found = |match_vec;

  always_comb begin
    fout = '0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      fout = fout | (first_vec[i] ? entry_frame[i] : '0);
    end
  end

  // Removal: the matching slot on a refill, else the oldest when full.
  assign full = (count == CNT_W'(TLB_ENTRIES));
  assign is_fill = (req_q == REQ_FILL);
  assign removed = is_fill && (found || full);

  always_comb begin
    if (found) begin
      rm_mask = ~(first_vec - TLB_ENTRIES'(1));
    end else if (full) begin
      rm_mask = '1;
    end else begin
      rm_mask = '0;
    end
  end

  // The new entry goes right after the surviving entries.
  assign wr_slot = count - CNT_W'(removed);
  assign count_next = is_fill ? wr_slot + CNT_W'(1) : count;

  // Each slot's neighbor toward the new end.
  always_comb begin
    for (int j = 0; j < TLB_ENTRIES - 1; j++) begin
      shift_page[j] = entry_page[j + 1];
      shift_frame[j] = entry_frame[j + 1];
    end
    shift_page[TLB_ENTRIES-1] = entry_page[TLB_ENTRIES-1];
    shift_frame[TLB_ENTRIES-1] = entry_frame[TLB_ENTRIES-1];
  end

  // Entry update: close the gap, then append the new pair.
  always_ff @(posedge clk) begin
    if (cmd.execute && is_fill) begin
      for (int j = 0; j < TLB_ENTRIES; j++) begin
        if (CNT_W'(j) == wr_slot) begin
          entry_page[j] <= page_q;
          entry_frame[j] <= frame_q;
        end else if (removed && rm_mask[j]) begin
          entry_page[j] <= shift_page[j];
          entry_frame[j] <= shift_frame[j];
        end
      end
    end
  end

  // Entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.execute) begin
      count <= count_next;
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      hit <= found;
      frame_out <= fout;
      occupancy <= OCC_W'(count_next);
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TLB_ENTRIES))
    else $error("entry count exceeds capacity");

  a_lookup_keeps: assert property (@(posedge clk) disable iff (rst)
    cmd.execute && !is_fill |=> count == $past(count))
    else $error("lookup changed the entry count");

  a_refill_keeps: assert property (@(posedge clk) disable iff (rst)
    cmd.execute && is_fill && found |=> count == $past(count))
    else $error("refill of a present page changed the entry count");

  a_fill_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.execute && is_fill |=> count != '0)
    else $error("buffer empty after a fill");
`endif

endmodule

### rtl/tlb_fifo_lookup_fill.sv
`timescale 1ns / 1ps
// A request beat is registered in the idle state when it is taken; the search, entry update
// and response load are then done in the execute state. The controller holds one request
// at a time, so a new beat is not taken until the last one has left the execute state.
// A stalled response holds the execute state until the response register frees up.
// Reset (rst, synchronous) empties the buffer, clears the response valid and returns
// the controller to idle so in_stall is low; entries are not cleared.

module tlb_fifo_lookup_fill #(
  parameter int TLB_ENTRIES = tfl_pkg::TLB_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        req_type,
  input  logic [tfl_pkg::PAGE_W-1:0]  page,
  input  logic [tfl_pkg::FRAME_W-1:0] frame,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        hit,
  output logic [tfl_pkg::FRAME_W-1:0] frame_out,
  output logic [tfl_pkg::OCC_W-1:0]   occupancy
);
  import tfl_pkg::*;

  ctl_cmd_t cmd;

  tfl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  tfl_dp #(
    .TLB_ENTRIES (TLB_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req_type  (req_type),
    .page      (page),
    .frame     (frame),
    .hit       (hit),
    .frame_out (frame_out),
    .occupancy (occupancy)
  );

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import tfl_pkg::*;

  localparam int ENTRIES = TLB_ENTRIES_DEF;
  localparam int RANDOM_ITEMS = 2000;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS = 10;

  // One response beat as the block presents it.
  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] frame_out;
    logic [OCC_W-1:0]   occupancy;
  } tlb_resp_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               req_type = REQ_LOOKUP;
  logic [PAGE_W-1:0]  page = '0;
  logic [FRAME_W-1:0] frame = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               hit;
  logic [FRAME_W-1:0] frame_out;
  logic [OCC_W-1:0]   occupancy;

  // Shadow copy of the buffer, oldest entry in slot 0.
  logic [PAGE_W-1:0]  shadow_page [ENTRIES];
  logic [FRAME_W-1:0] shadow_frame [ENTRIES];
  int                 shadow_count = 0;

  tlb_resp_t access_resp_q[$];
  int        fail_cnt = 0;
  int        cycle_cnt = 0;
  int        stall_mode = 0;
  int        stall_phase = 0;

  tlb_fifo_lookup_fill #(
    .TLB_ENTRIES(ENTRIES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .req_type(req_type),
    .page(page),
    .frame(frame),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .hit(hit),
    .frame_out(frame_out),
    .occupancy(occupancy)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Search the shadow buffer, apply a fill, and return the response the block owes.
  function automatic tlb_resp_t predict_access(logic rt, logic [PAGE_W-1:0] pg,
                                               logic [FRAME_W-1:0] fr);
    tlb_resp_t r;
    int        match;
    int        pos;
    r = '0;
    match = -1;
    for (int i = 0; i < shadow_count; i++) begin
      if (match < 0 && shadow_page[i] == pg) begin
        match = i;
      end
    end
    if (match >= 0) begin
      r.hit = 1'b1;
      r.frame_out = shadow_frame[match];
    end
    if (rt == REQ_FILL) begin
      // A present page is pulled out; otherwise a full buffer drops its oldest entry.
      if (match >= 0) begin
        pos = match;
      end else if (shadow_count == ENTRIES) begin
        pos = 0;
      end else begin
        pos = -1;
      end
      if (pos >= 0) begin
        for (int j = pos; j < shadow_count - 1; j++) begin
          shadow_page[j] = shadow_page[j + 1];
          shadow_frame[j] = shadow_frame[j + 1];
        end
        shadow_count--;
      end
      shadow_page[shadow_count] = pg;
      shadow_frame[shadow_count] = fr;
      shadow_count++;
    end
    r.occupancy = OCC_W'(shadow_count);
    return r;
  endfunction

  function automatic void flag_error(string msg);
    fail_cnt++;
    if (fail_cnt <= MAX_REPORTS) begin
      $display("ERROR at cycle %0d: %s", cycle_cnt, msg);
    end
  endfunction

  // Present one request beat and hold it until the block takes it.
  task automatic send_req(input logic rt, input logic [PAGE_W-1:0] pg,
                          input logic [FRAME_W-1:0] fr);
    @(negedge clk);
    in_valid <= 1'b1;
    req_type <= rt;
    page <= pg;
    frame <= fr;
    do @(posedge clk); while (in_stall);
    access_resp_q.push_back(predict_access(rt, pg, fr));
  endtask

  // Drop valid for a number of cycles, with junk on the payload meanwhile.
  task automatic idle_gap(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid <= 1'b0;
      req_type <= 1'($urandom);
      page <= PAGE_W'($urandom);
      frame <= FRAME_W'($urandom);
    end
  endtask

  task automatic test_empty_lookup();
    send_req(REQ_LOOKUP, 8'h00, 8'hFF);
    send_req(REQ_LOOKUP, 8'hFF, 8'h00);
  endtask

  task automatic test_fill_extremes();
    send_req(REQ_FILL, 8'h00, 8'h00);
    send_req(REQ_FILL, 8'hFF, 8'hFF);
    send_req(REQ_LOOKUP, 8'h00, 8'h5A);
    send_req(REQ_LOOKUP, 8'hFF, 8'hA5);
  endtask

  // A fill of a present page returns the old frame and moves the page to the newest slot.
  task automatic test_refill_present();
    send_req(REQ_FILL, 8'h00, 8'hA5);
    send_req(REQ_FILL, 8'h00, 8'h5A);
  endtask

  // Fill up to capacity, then one more fill must evict the oldest page.
  task automatic test_overflow_evict();
    for (int p = 1; p <= ENTRIES - 2; p++) begin
      send_req(REQ_FILL, PAGE_W'(p), FRAME_W'(p * 17));
    end
    send_req(REQ_FILL, 8'hC8, 8'h3C);
    send_req(REQ_LOOKUP, 8'hFF, 8'h00);
  endtask

  // Mostly pages from a small moving pool so hits, refills and evictions are common.
  task automatic test_random_traffic();
    int                sent;
    int                burst;
    int                fill_pct;
    logic [PAGE_W-1:0] pool_base;
    logic              rt;
    logic [PAGE_W-1:0] pg;
    sent = 0;
    pool_base = PAGE_W'($urandom);
    fill_pct = 50;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 15) == 0) begin
        pool_base = PAGE_W'($urandom);
        fill_pct = $urandom_range(20, 80);
      end
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      repeat (burst) begin
        rt = ($urandom_range(0, 99) < fill_pct) ? REQ_FILL : REQ_LOOKUP;
        if ($urandom_range(0, 3) != 0) begin
          pg = pool_base ^ PAGE_W'($urandom_range(0, 23));
        end else begin
          pg = PAGE_W'($urandom);
        end
        send_req(rt, pg, FRAME_W'($urandom));
        sent++;
      end
      idle_gap($urandom_range(0, 7));
    end
  endtask

  // Receiver stall pattern: phases of no stall, light, heavy and alternating stall.
  always @(negedge clk) begin
    if (stall_phase == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_phase <= $urandom_range(20, 80);
    end else begin
      stall_phase <= stall_phase - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 9) < 6);
      default: out_stall <= ~out_stall;
    endcase
  end

  // Compare every accepted response beat with the oldest pending prediction.
  always @(posedge clk) begin : resp_check
    tlb_resp_t want;
    if (!rst && out_valid && !out_stall) begin
      if (access_resp_q.size() == 0) begin
        flag_error($sformatf("response beat with no request pending (hit %0d frame %0d occ %0d)",
                             hit, frame_out, occupancy));
      end else begin
        want = access_resp_q.pop_front();
        if (hit !== want.hit) begin
          flag_error($sformatf("hit expected %0d, got %0d", want.hit, hit));
        end
        if (frame_out !== want.frame_out) begin
          flag_error($sformatf("frame_out expected %0d, got %0d", want.frame_out, frame_out));
        end
        if (occupancy !== want.occupancy) begin
          flag_error($sformatf("occupancy expected %0d, got %0d", want.occupancy, occupancy));
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_lookup();
    test_fill_extremes();
    test_refill_present();
    test_overflow_evict();
    test_random_traffic();

    @(negedge clk);
    in_valid <= 1'b0;
    while (access_resp_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### sim.f
rtl/tfl_pkg.sv
rtl/tfl_ctrl.sv
rtl/tfl_dp.sv
rtl/tlb_fifo_lookup_fill.sv
tb/testbench.sv
